[hdl/psp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and register codes of the point to segment projection block.
// ----------------------------------------------------------------------------
package psp_pkg;

	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_END_X   = 2'd2,
		REG_END_Y   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic on;
		logic degen;
		logic neg_x;
		logic neg_y;
		logic big_x;
		logic big_y;
	} flags_t;

endpackage

[hdl/psp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_front
// Deltas, dot product, squared length and projection numerators, seven stages.
// ----------------------------------------------------------------------------
module psp_front
	import psp_pkg::*;
#(
	parameter int CW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [CW-1:0]   qx_in,
	input  logic signed [CW-1:0]   qy_in,
	input  logic signed [CW-1:0]   sx,
	input  logic signed [CW-1:0]   sy,
	input  logic signed [CW-1:0]   ex,
	input  logic signed [CW-1:0]   ey,
	output logic                   out_vld,
	output logic [3*(CW+1)-1:0]    num_x,
	output logic [3*(CW+1)-1:0]    num_y,
	output logic [2*(CW+1)-1:0]    len2,
	output logic signed [CW-1:0]   qx_out,
	output logic signed [CW-1:0]   qy_out,
	output flags_t                 flags
);

	localparam int D  = CW + 1;
	localparam int P  = 2 * D;
	localparam int NW = 3 * D;
	localparam int QB = CW + 2;

	logic [7:1] vld_s;

	logic signed [CW-1:0] qx_s1, qx_s2, qx_s3, qx_s4, qx_s5, qx_s6, qx_s7;
	logic signed [CW-1:0] qy_s1, qy_s2, qy_s3, qy_s4, qy_s5, qy_s6, qy_s7;
	logic signed [D-1:0]  dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [P-1:0]  pxx_s2, pyy_s2, lxx_s2, lyy_s2;
	logic [D-1:0]         dmx_s2, dmy_s2, dmx_s3, dmy_s3, dmx_s4, dmy_s4;
	logic                 ngx_s2, ngy_s2, ngx_s3, ngy_s3, ngx_s4, ngy_s4, ngx_s5, ngy_s5;
	logic signed [P:0]    dot_s3;
	logic [P-1:0]         len2_s3, len2_s4, len2_s5, len2_s6, len2_s7;
	logic [P-1:0]         mag_s4;
	logic                 neg_s4, neg_s5;
	logic [P-1:0]         plx_s5, phx_s5, ply_s5, phy_s5;
	logic [NW-1:0]        numx_s6, numy_s6, numx_s7, numy_s7;
	flags_t               fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7;
	flags_t               fl_d2, fl_d4, fl_d6, fl_d7;
	logic signed [P:0]    dot_abs;

	assign dot_abs = dot_s3[P] ? -dot_s3 : dot_s3;

	// next flag values of the stages that set a flag
	always_comb begin
		fl_d2       = '0;
		fl_d2.degen = (dx2_s1 == '0) && (dy2_s1 == '0);
		fl_d4       = fl_s3;
		fl_d4.on    = !dot_s3[P] && (dot_s3[P-1:0] <= len2_s3);
		fl_d6       = fl_s5;
		fl_d6.neg_x = neg_s5 ^ ngx_s5;
		fl_d6.neg_y = neg_s5 ^ ngy_s5;
		fl_d7       = fl_s6;
		fl_d7.big_x = {1'b0, numx_s6} >= {len2_s6, {QB{1'b0}}};
		fl_d7.big_y = {1'b0, numy_s6} >= {len2_s6, {QB{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: deltas
			qx_s1  <= qx_in;
			qy_s1  <= qy_in;
			dx1_s1 <= {qx_in[CW-1], qx_in} - {sx[CW-1], sx};
			dy1_s1 <= {qy_in[CW-1], qy_in} - {sy[CW-1], sy};
			dx2_s1 <= {ex[CW-1], ex} - {sx[CW-1], sx};
			dy2_s1 <= {ey[CW-1], ey} - {sy[CW-1], sy};
			// s2: products
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			pxx_s2 <= dx1_s1 * dx2_s1;
			pyy_s2 <= dy1_s1 * dy2_s1;
			lxx_s2 <= dx2_s1 * dx2_s1;
			lyy_s2 <= dy2_s1 * dy2_s1;
			dmx_s2 <= dx2_s1[D-1] ? -dx2_s1 : dx2_s1;
			dmy_s2 <= dy2_s1[D-1] ? -dy2_s1 : dy2_s1;
			ngx_s2 <= dx2_s1[D-1];
			ngy_s2 <= dy2_s1[D-1];
			fl_s2  <= fl_d2;
			// s3: dot product and squared length
			qx_s3   <= qx_s2;
			qy_s3   <= qy_s2;
			dot_s3  <= pxx_s2 + pyy_s2;
			len2_s3 <= lxx_s2 + lyy_s2;
			dmx_s3  <= dmx_s2;
			dmy_s3  <= dmy_s2;
			ngx_s3  <= ngx_s2;
			ngy_s3  <= ngy_s2;
			fl_s3   <= fl_s2;
			// s4: magnitude and range test
			qx_s4   <= qx_s3;
			qy_s4   <= qy_s3;
			mag_s4  <= dot_abs[P-1:0];
			neg_s4  <= dot_s3[P];
			len2_s4 <= len2_s3;
			dmx_s4  <= dmx_s3;
			dmy_s4  <= dmy_s3;
			ngx_s4  <= ngx_s3;
			ngy_s4  <= ngy_s3;
			fl_s4   <= fl_d4;
			// s5: partial products of the numerators
			qx_s5   <= qx_s4;
			qy_s5   <= qy_s4;
			plx_s5  <= mag_s4[D-1:0] * dmx_s4;
			phx_s5  <= mag_s4[P-1:D] * dmx_s4;
			ply_s5  <= mag_s4[D-1:0] * dmy_s4;
			phy_s5  <= mag_s4[P-1:D] * dmy_s4;
			neg_s5  <= neg_s4;
			ngx_s5  <= ngx_s4;
			ngy_s5  <= ngy_s4;
			len2_s5 <= len2_s4;
			fl_s5   <= fl_s4;
			// s6: numerators
			qx_s6   <= qx_s5;
			qy_s6   <= qy_s5;
			numx_s6 <= {phx_s5, {D{1'b0}}} + NW'(plx_s5);
			numy_s6 <= {phy_s5, {D{1'b0}}} + NW'(ply_s5);
			len2_s6 <= len2_s5;
			fl_s6   <= fl_d6;
			// s7: quotient overflow
			qx_s7   <= qx_s6;
			qy_s7   <= qy_s6;
			numx_s7 <= numx_s6;
			numy_s7 <= numy_s6;
			len2_s7 <= len2_s6;
			fl_s7   <= fl_d7;
		end
	end

	assign out_vld = vld_s[7];
	assign num_x   = numx_s7;
	assign num_y   = numy_s7;
	assign len2    = len2_s7;
	assign qx_out  = qx_s7;
	assign qy_out  = qy_s7;
	assign flags   = fl_s7;

endmodule

[hdl/psp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared denominator.
// ----------------------------------------------------------------------------
module psp_div #(
	parameter int CW = 32,
	parameter int SW = 70
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [3*(CW+1)-1:0]  num_x,
	input  logic [3*(CW+1)-1:0]  num_y,
	input  logic [2*(CW+1)-1:0]  den,
	input  logic [SW-1:0]        side_in,
	output logic                 out_vld,
	output logic [CW+1:0]        quo_x,
	output logic [CW+1:0]        quo_y,
	output logic [2*(CW+1)-1:0]  rem_x,
	output logic [2*(CW+1)-1:0]  rem_y,
	output logic [2*(CW+1)-1:0]  den_out,
	output logic [SW-1:0]        side_out
);

	localparam int D  = CW + 1;
	localparam int P  = 2 * D;
	localparam int QB = CW + 2;

	logic [QB:0]    vld_s;
	logic [P-1:0]   rx_s   [0:QB];
	logic [P-1:0]   ry_s   [0:QB];
	logic [QB-1:0]  qx_s   [0:QB];
	logic [QB-1:0]  qy_s   [0:QB];
	logic [QB-1:0]  lx_s   [0:QB];
	logic [QB-1:0]  ly_s   [0:QB];
	logic [P-1:0]   den_s  [0:QB];
	logic [SW-1:0]  side_s [0:QB];
	logic [P:0]     tx     [1:QB];
	logic [P:0]     ty     [1:QB];
	logic [QB:1]    gx, gy;

	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			tx[k] = {rx_s[k-1], lx_s[k-1][QB-1]};
			ty[k] = {ry_s[k-1], ly_s[k-1][QB-1]};
			gx[k] = tx[k] >= {1'b0, den_s[k-1]};
			gy[k] = ty[k] >= {1'b0, den_s[k-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= P'(num_x >> QB);
			ry_s[0]   <= P'(num_y >> QB);
			lx_s[0]   <= num_x[QB-1:0];
			ly_s[0]   <= num_y[QB-1:0];
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int k = 1; k <= QB; k++) begin
				rx_s[k]   <= gx[k] ? P'(tx[k] - {1'b0, den_s[k-1]}) : tx[k][P-1:0];
				ry_s[k]   <= gy[k] ? P'(ty[k] - {1'b0, den_s[k-1]}) : ty[k][P-1:0];
				qx_s[k]   <= {qx_s[k-1][QB-2:0], gx[k]};
				qy_s[k]   <= {qy_s[k-1][QB-2:0], gy[k]};
				lx_s[k]   <= {lx_s[k-1][QB-2:0], 1'b0};
				ly_s[k]   <= {ly_s[k-1][QB-2:0], 1'b0};
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[QB];
	assign quo_x    = qx_s[QB];
	assign quo_y    = qy_s[QB];
	assign rem_x    = rx_s[QB];
	assign rem_y    = ry_s[QB];
	assign den_out  = den_s[QB];
	assign side_out = side_s[QB];

endmodule

[hdl/psp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_back
// Rounding, clamping and saturation of the projection, then the squared
// distance, seven stages.
// ----------------------------------------------------------------------------
module psp_back
	import psp_pkg::*;
#(
	parameter int CW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [CW+1:0]         quo_x,
	input  logic [CW+1:0]         quo_y,
	input  logic [2*(CW+1)-1:0]   rem_x,
	input  logic [2*(CW+1)-1:0]   rem_y,
	input  logic [2*(CW+1)-1:0]   den,
	input  logic signed [CW-1:0]  qx,
	input  logic signed [CW-1:0]  qy,
	input  flags_t                fl_in,
	input  logic signed [CW-1:0]  sx,
	input  logic signed [CW-1:0]  sy,
	output logic                  out_vld,
	output logic signed [CW-1:0]  nx,
	output logic signed [CW-1:0]  ny,
	output logic [2*(CW+1)-1:0]   sq,
	output flags_t                fl_out
);

	localparam int D  = CW + 1;
	localparam int P  = 2 * D;
	localparam int QB = CW + 2;
	localparam int VW = CW + 3;
	localparam logic [VW-1:0] LIM = VW'(1) << (CW + 1);
	localparam logic signed [VW-1:0] MAXV = {{4{1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [VW-1:0] MINV = {{4{1'b1}}, {(CW-1){1'b0}}};

	logic [7:1] vld_s;

	logic signed [CW-1:0] qx_s1, qx_s2, qx_s3, qx_s4, qy_s1, qy_s2, qy_s3, qy_s4;
	logic [VW-1:0]        qrx_s1, qry_s1;
	logic [QB-1:0]        qvx_s2, qvy_s2;
	logic signed [VW-1:0] vx_s3, vy_s3;
	logic signed [CW-1:0] nx_s4, ny_s4, nx_s5, ny_s5, nx_s6, ny_s6, nx_s7, ny_s7;
	logic signed [D-1:0]  ex_s5, ey_s5;
	logic signed [P-1:0]  sqx_s6, sqy_s6;
	logic [P-1:0]         s_s7;
	flags_t               fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7;
	logic                 rnd_x, rnd_y;
	logic signed [VW-1:0] bx, by, ux, uy;

	assign rnd_x = {rem_x, 1'b0} >= {1'b0, den};
	assign rnd_y = {rem_y, 1'b0} >= {1'b0, den};
	assign bx    = VW'(sx);
	assign by    = VW'(sy);
	assign ux    = {1'b0, qvx_s2};
	assign uy    = {1'b0, qvy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// b1: round half away from zero on the magnitude
			qrx_s1 <= {1'b0, quo_x} + VW'(rnd_x);
			qry_s1 <= {1'b0, quo_y} + VW'(rnd_y);
			qx_s1  <= qx;
			qy_s1  <= qy;
			fl_s1  <= fl_in;
			// b2: clamp the offset magnitude
			qvx_s2 <= (fl_s1.big_x || qrx_s1 > LIM) ? LIM[QB-1:0] : qrx_s1[QB-1:0];
			qvy_s2 <= (fl_s1.big_y || qry_s1 > LIM) ? LIM[QB-1:0] : qry_s1[QB-1:0];
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			fl_s2  <= fl_s1;
			// b3: add to the start point
			vx_s3  <= fl_s2.neg_x ? bx - ux : bx + ux;
			vy_s3  <= fl_s2.neg_y ? by - uy : by + uy;
			qx_s3  <= qx_s2;
			qy_s3  <= qy_s2;
			fl_s3  <= fl_s2;
			// b4: saturate
			nx_s4  <= (vx_s3 > MAXV) ? MAXV[CW-1:0] :
			          (vx_s3 < MINV) ? MINV[CW-1:0] : vx_s3[CW-1:0];
			ny_s4  <= (vy_s3 > MAXV) ? MAXV[CW-1:0] :
			          (vy_s3 < MINV) ? MINV[CW-1:0] : vy_s3[CW-1:0];
			qx_s4  <= qx_s3;
			qy_s4  <= qy_s3;
			fl_s4  <= fl_s3;
			// b5: error vector
			ex_s5  <= {qx_s4[CW-1], qx_s4} - {nx_s4[CW-1], nx_s4};
			ey_s5  <= {qy_s4[CW-1], qy_s4} - {ny_s4[CW-1], ny_s4};
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			fl_s5  <= fl_s4;
			// b6: squares
			sqx_s6 <= ex_s5 * ex_s5;
			sqy_s6 <= ey_s5 * ey_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			fl_s6  <= fl_s5;
			// b7: sum of squares
			s_s7   <= sqx_s6 + sqy_s6;
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
			fl_s7  <= fl_s6;
		end
	end

	assign out_vld = vld_s[7];
	assign nx      = nx_s7;
	assign ny      = ny_s7;
	assign sq      = s_s7;
	assign fl_out  = fl_s7;

endmodule

[hdl/psp_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_sqrt
// Pipelined integer square root (floor), one result bit per stage.
// ----------------------------------------------------------------------------
module psp_sqrt #(
	parameter int CW = 32,
	parameter int SW = 70
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [2*(CW+1)-1:0]  sq,
	input  logic [SW-1:0]        side_in,
	output logic                 out_vld,
	output logic [CW:0]          root,
	output logic [SW-1:0]        side_out
);

	localparam int RB = CW + 1;
	localparam int P  = 2 * RB;
	localparam int TW = 2 * RB + 1;

	logic [RB:0]    vld_s;
	logic [P-1:0]   rem_s  [0:RB];
	logic [RB-1:0]  res_s  [0:RB];
	logic [SW-1:0]  side_s [0:RB];
	logic [TW-1:0]  trial  [1:RB];
	logic [RB-1:0]  bitm   [1:RB];
	logic [RB:1]    gk;

	always_comb begin
		for (int k = 1; k <= RB; k++) begin
			trial[k] = (TW'(res_s[k-1]) << (RB - k + 1)) | (TW'(1) << (2 * (RB - k)));
			bitm[k]  = RB'(1) << (RB - k);
			gk[k]    = TW'(rem_s[k-1]) >= trial[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RB-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= sq;
			res_s[0]  <= '0;
			side_s[0] <= side_in;
			for (int k = 1; k <= RB; k++) begin
				rem_s[k]  <= gk[k] ? P'(TW'(rem_s[k-1]) - trial[k]) : rem_s[k-1];
				res_s[k]  <= res_s[k-1] | (gk[k] ? bitm[k] : '0);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[RB];
	assign root     = res_s[RB];
	assign side_out = side_s[RB];

endmodule

[hdl/point_segment_projection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_projection
// Projects queries onto a configured segment; the distance is all ones off it.
// ----------------------------------------------------------------------------
// Usage:
//   The segment endpoints are written over the APB port (start_x at 0x0,
//   start_y at 0x4, end_x at 0x8, end_y at 0xC) while no query is in flight.
//   Queries enter on the s_ stream, tdata = {query_y, query_x}; one result
//   per query leaves on the m_ stream, tdata = {separation, near_y, near_x},
//   tuser = {degenerate, on_segment}.
//   Throughput is one query per cycle while s_tready is high. A query passes
//   through the front stages, the bit-per-stage divider, the back stages, the
//   bit-per-stage square root pipeline and the output register to m_tvalid.
//   Reset clears the endpoints to zero and empties the pipeline; a query
//   can be accepted at the first clock edge after reset is released.
//   When the receiver stalls, the pipeline keeps running until one extra
//   result sits in the skid register, then s_tready drops and the whole
//   pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_segment_projection
	import psp_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// query_x, query_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]            s_tdata,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// near_x, near_y, separation
	output logic [((3*COORD_WIDTH+1+7)/8)*8-1:0]          m_tdata,
	// on_segment, degenerate
	output logic [1:0]                                    m_tuser,
	input  logic                                          psel,
	input  logic                                          penable,
	input  logic                                          pwrite,
	input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0]       paddr,
	input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]     pwdata,
	output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]     prdata,
	output logic                                          pready
);

	localparam int CW     = COORD_WIDTH;
	localparam int D      = CW + 1;
	localparam int P      = 2 * D;
	localparam int NW     = 3 * D;
	localparam int QB     = CW + 2;
	localparam int DATA_W = (CW > 32) ? 64 : 32;
	localparam int ADDR_W = (CW > 32) ? 5 : 4;
	localparam int TDW    = ((3*CW+1+7)/8)*8;
	localparam int FLW    = $bits(flags_t);
	localparam int SW     = 2 * CW + FLW;

	logic signed [CW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;

	logic                 en;
	logic                 f_vld, d_vld, b_vld, r_vld, push;
	logic [NW-1:0]        f_num_x, f_num_y;
	logic [P-1:0]         f_len2;
	logic signed [CW-1:0] f_qx, f_qy;
	flags_t               f_fl;
	logic [QB-1:0]        d_quo_x, d_quo_y;
	logic [P-1:0]         d_rem_x, d_rem_y, d_den;
	logic [SW-1:0]        d_side;
	logic signed [CW-1:0] d_qx, d_qy;
	flags_t               d_fl;
	logic signed [CW-1:0] b_nx, b_ny;
	logic [P-1:0]         b_sq;
	flags_t               b_fl;
	logic [D-1:0]         r_root;
	logic [SW-1:0]        r_side;
	logic signed [CW-1:0] r_nx, r_ny;
	flags_t               r_fl;

	logic [CW-1:0]        fin_nx, fin_ny;
	logic [D-1:0]         fin_sep;
	logic                 fin_on, fin_deg;

	logic                 out_vld_q, skid_vld_q;
	logic [CW-1:0]        out_nx_q, out_ny_q, skid_nx_q, skid_ny_q;
	logic [D-1:0]         out_sep_q, skid_sep_q;
	logic                 out_on_q, out_deg_q, skid_on_q, skid_deg_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1 -: 2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_START_X: start_x_q <= pwdata[CW-1:0];
				REG_START_Y: start_y_q <= pwdata[CW-1:0];
				REG_END_X:   end_x_q   <= pwdata[CW-1:0];
				REG_END_Y:   end_y_q   <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_START_X: prdata = DATA_W'(start_x_q);
			REG_START_Y: prdata = DATA_W'(start_y_q);
			REG_END_X:   prdata = DATA_W'(end_x_q);
			REG_END_Y:   prdata = DATA_W'(end_y_q);
			default:     prdata = '0;
		endcase
	end

	// pipeline
	assign en       = !skid_vld_q;
	assign s_tready = en;

	psp_front #(.CW(CW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.qx_in   (s_tdata[CW-1:0]),
		.qy_in   (s_tdata[2*CW-1:CW]),
		.sx      (start_x_q),
		.sy      (start_y_q),
		.ex      (end_x_q),
		.ey      (end_y_q),
		.out_vld (f_vld),
		.num_x   (f_num_x),
		.num_y   (f_num_y),
		.len2    (f_len2),
		.qx_out  (f_qx),
		.qy_out  (f_qy),
		.flags   (f_fl)
	);

	psp_div #(.CW(CW), .SW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.num_x    (f_num_x),
		.num_y    (f_num_y),
		.den      (f_len2),
		.side_in  ({f_qx, f_qy, f_fl}),
		.out_vld  (d_vld),
		.quo_x    (d_quo_x),
		.quo_y    (d_quo_y),
		.rem_x    (d_rem_x),
		.rem_y    (d_rem_y),
		.den_out  (d_den),
		.side_out (d_side)
	);

	assign {d_qx, d_qy, d_fl} = d_side;

	psp_back #(.CW(CW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (d_vld),
		.quo_x   (d_quo_x),
		.quo_y   (d_quo_y),
		.rem_x   (d_rem_x),
		.rem_y   (d_rem_y),
		.den     (d_den),
		.qx      (d_qx),
		.qy      (d_qy),
		.fl_in   (d_fl),
		.sx      (start_x_q),
		.sy      (start_y_q),
		.out_vld (b_vld),
		.nx      (b_nx),
		.ny      (b_ny),
		.sq      (b_sq),
		.fl_out  (b_fl)
	);

	psp_sqrt #(.CW(CW), .SW(SW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (b_vld),
		.sq       (b_sq),
		.side_in  ({b_nx, b_ny, b_fl}),
		.out_vld  (r_vld),
		.root     (r_root),
		.side_out (r_side)
	);

	assign {r_nx, r_ny, r_fl} = r_side;

	// final selection, degenerate segment reports the start point
	assign fin_deg = r_fl.degen;
	assign fin_on  = r_fl.on && !r_fl.degen;
	assign fin_nx  = r_fl.degen ? start_x_q : r_nx;
	assign fin_ny  = r_fl.degen ? start_y_q : r_ny;
	assign fin_sep = fin_on ? r_root : '1;
	assign push    = en && r_vld;

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_nx_q  <= skid_nx_q;
				out_ny_q  <= skid_ny_q;
				out_sep_q <= skid_sep_q;
				out_on_q  <= skid_on_q;
				out_deg_q <= skid_deg_q;
			end else begin
				out_nx_q  <= fin_nx;
				out_ny_q  <= fin_ny;
				out_sep_q <= fin_sep;
				out_on_q  <= fin_on;
				out_deg_q <= fin_deg;
			end
		end else if (push) begin
			skid_nx_q  <= fin_nx;
			skid_ny_q  <= fin_ny;
			skid_sep_q <= fin_sep;
			skid_on_q  <= fin_on;
			skid_deg_q <= fin_deg;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = TDW'({out_sep_q, out_ny_q, out_nx_q});
	assign m_tuser  = {out_deg_q, out_on_q};

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && m_tready |=> !skid_vld_q)
		else $error("skid refilled while the pipeline was stalled");

	a_off_is_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_on_q |-> (&out_sep_q))
		else $error("off-segment result without all-ones distance");

	a_degen_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_deg_q |-> !out_on_q)
		else $error("degenerate segment reported as on segment");
`endif

endmodule
